>>> sv/ultrasonic_echo_ranger_alarm_macros.svh
// Assertion macros for the ultrasonic echo ranger RTL.
// Expects a clock named clk and an active-high reset named rst in the using module.
`ifndef ULTRASONIC_ECHO_RANGER_ALARM_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_ALARM_MACROS_SVH

`ifndef SYNTHESIS
`define UERA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UERA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UERA_ASSERT_SAME(lbl, ante, cons, msg)
`define UERA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/uera_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the ultrasonic echo ranger with distance alarm.
// Used by uera_dist and ultrasonic_echo_ranger_alarm; depends on nothing.
package uera_pkg;

  localparam int CNT_BITS   = 10;
  localparam int DIST_BITS  = 9;
  localparam int LIMIT_BITS = 9;

  localparam logic [1:0] FUNC_TRIGGER  = 2'd0;
  localparam logic [1:0] FUNC_ECHO     = 2'd1;
  localparam logic [1:0] FUNC_OVERFLOW = 2'd2;

  localparam logic [1:0] ALARM_NONE = 2'd0;
  localparam logic [1:0] ALARM_SLOW = 2'd1;
  localparam logic [1:0] ALARM_FAST = 2'd2;
  localparam logic [1:0] ALARM_ON   = 2'd3;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_FAR     = 2'd1;
  localparam logic [1:0] REG_MID     = 2'd2;
  localparam logic [1:0] REG_NEAR    = 2'd3;

  localparam logic [CNT_BITS-1:0]   TIMEOUT_RESET = 10'd730;
  localparam logic [LIMIT_BITS-1:0] FAR_RESET     = 9'd30;
  localparam logic [LIMIT_BITS-1:0] MID_RESET     = 9'd20;
  localparam logic [LIMIT_BITS-1:0] NEAR_RESET    = 9'd10;

  // Distance is counts / 600, saturated at 511. Counts at or above 512 * 600
  // saturate; below that, counts / 600 = (counts / 8) / 75, and the 16-bit
  // quotient by 75 is an exact reciprocal multiply with a 22-bit shift.
  localparam logic [DIST_BITS-1:0] DIST_MAX    = 9'd511;
  localparam logic [31:0]          SAT_COUNTS  = 32'd307200;
  localparam logic [15:0]          RECIP_75    = 16'd55925;
  localparam int                   RECIP_SHIFT = 22;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] far_limit;
    logic [LIMIT_BITS-1:0] mid_limit;
    logic [LIMIT_BITS-1:0] near_limit;
  } limits_t;

  typedef struct packed {
    logic                 trigger_fire;
    logic                 clear_timer;
    logic                 distance_valid;
    logic [DIST_BITS-1:0] distance;
    logic [1:0]           alarm_mode;
    logic                 timed_out;
  } result_t;

endpackage

>>> sv/uera_dist.sv
`timescale 1ns / 1ps
// Distance computation and alarm classification for one echo measurement.
// Depends on uera_pkg.
module uera_dist
  import uera_pkg::*;
#(
  parameter int TIMER_BITS = 8
) (
  input  logic [CNT_BITS-1:0]   overflow_count,
  input  logic [TIMER_BITS-1:0] timer_low,
  input  limits_t               limits,
  output logic [DIST_BITS-1:0]  distance,
  output logic [1:0]            alarm_mode
);

  localparam int CW = CNT_BITS + TIMER_BITS;

  logic [CW-1:0] counts;
  logic [31:0]   counts_ext;
  logic [15:0]   scaled;
  logic [31:0]   prod;

  assign counts     = {overflow_count, timer_low};
  assign counts_ext = 32'(counts);
  assign scaled     = counts_ext[18:3];
  assign prod       = scaled * RECIP_75;
  assign distance   = (counts_ext >= SAT_COUNTS) ? DIST_MAX : prod[RECIP_SHIFT +: DIST_BITS];

  always_comb begin
    if (distance < limits.far_limit && distance > limits.mid_limit) begin
      alarm_mode = ALARM_SLOW;
    end else if (distance < limits.mid_limit && distance > limits.near_limit) begin
      alarm_mode = ALARM_FAST;
    end else if (distance <= limits.near_limit) begin
      alarm_mode = ALARM_ON;
    end else begin
      alarm_mode = ALARM_NONE;
    end
  end

endmodule

>>> sv/ultrasonic_echo_ranger_alarm.sv
`timescale 1ns / 1ps
// Top level of the ultrasonic echo ranger: event handling, state and registers.
// Depends on uera_pkg, uera_dist and ultrasonic_echo_ranger_alarm_macros.svh.
//
//   channel  direction  signals                       word
//   s_*      in         s_tvalid s_tready s_tdata     one event
//   m_*      out        m_tvalid m_tready m_tdata     one result per event
//   apb      in         psel penable pwrite paddr     register writes and reads
//
// Every event is decoded against the state and written to
// the result register at the edge where it is accepted.
// The event path runs combinationally through the 16x16 reciprocal multiply in uera_dist.
// A new event is accepted whenever the result register is empty or being taken.
// Reset is synchronous; it disarms, clears the echo phase, the overflow count and
// the result valid flag m_tvalid, and restores the register reset values.
`include "ultrasonic_echo_ranger_alarm_macros.svh"

module ultrasonic_echo_ranger_alarm
  import uera_pkg::*;
#(
  parameter int TIMER_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // timer_low
  input  logic [((TIMER_BITS+7)/8)*8-1:0]    s_tdata,
  // func
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // trigger_fire, clear_timer, distance, alarm_mode, timed_out
  output logic [15:0]                        m_tdata,
  // distance_valid
  output logic [0:0]                         m_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic                  armed;
  logic                  armed_next;
  logic                  echo_high;
  logic                  echo_high_next;
  logic [CNT_BITS-1:0]   overflow_count;
  logic [CNT_BITS-1:0]   overflow_count_next;
  logic [CNT_BITS-1:0]   count_inc;
  logic [CNT_BITS-1:0]   timeout_overflows;
  limits_t               limits;
  result_t               result;
  result_t               result_next;
  logic [TIMER_BITS-1:0] timer_low;
  logic [DIST_BITS-1:0]  meas_distance;
  logic [1:0]            meas_alarm;
  logic                  accept;
  logic                  cfg_write;

  assign timer_low = s_tdata[TIMER_BITS-1:0];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign count_inc = overflow_count + 1'b1;

  uera_dist #(
    .TIMER_BITS(TIMER_BITS)
  ) u_dist (
    .overflow_count(overflow_count),
    .timer_low     (timer_low),
    .limits        (limits),
    .distance      (meas_distance),
    .alarm_mode    (meas_alarm)
  );

  always_comb begin
    result_next         = '0;
    armed_next          = armed;
    echo_high_next      = echo_high;
    overflow_count_next = overflow_count;
    case (s_tuser)
      FUNC_TRIGGER: begin
        if (!armed) begin
          armed_next               = 1'b1;
          result_next.trigger_fire = 1'b1;
        end
      end
      FUNC_ECHO: begin
        if (armed) begin
          overflow_count_next = '0;
          if (!echo_high) begin
            echo_high_next          = 1'b1;
            result_next.clear_timer = 1'b1;
          end else begin
            echo_high_next             = 1'b0;
            result_next.distance_valid = 1'b1;
            result_next.distance       = meas_distance;
            result_next.alarm_mode     = meas_alarm;
          end
        end
      end
      FUNC_OVERFLOW: begin
        if (count_inc == timeout_overflows) begin
          armed_next              = 1'b0;
          echo_high_next          = 1'b0;
          overflow_count_next     = '0;
          result_next.clear_timer = 1'b1;
          result_next.timed_out   = 1'b1;
        end else begin
          overflow_count_next = count_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      echo_high      <= 1'b0;
      overflow_count <= '0;
      m_tvalid       <= 1'b0;
    end else if (accept) begin
      armed          <= armed_next;
      echo_high      <= echo_high_next;
      overflow_count <= overflow_count_next;
      m_tvalid       <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_overflows <= TIMEOUT_RESET;
      limits.far_limit  <= FAR_RESET;
      limits.mid_limit  <= MID_RESET;
      limits.near_limit <= NEAR_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TIMEOUT: timeout_overflows <= pwdata[CNT_BITS-1:0];
        REG_FAR:     limits.far_limit  <= pwdata[LIMIT_BITS-1:0];
        REG_MID:     limits.mid_limit  <= pwdata[LIMIT_BITS-1:0];
        REG_NEAR:    limits.near_limit <= pwdata[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT: prdata = 32'(timeout_overflows);
      REG_FAR:     prdata = 32'(limits.far_limit);
      REG_MID:     prdata = 32'(limits.mid_limit);
      REG_NEAR:    prdata = 32'(limits.near_limit);
      default:     prdata = '0;
    endcase
  end

  assign m_tdata = {2'b00, result.timed_out, result.alarm_mode, result.distance,
                    result.clear_timer, result.trigger_fire};
  assign m_tuser = result.distance_valid;

  `UERA_ASSERT_SAME(a_echo_needs_arm, echo_high, armed, "echo phase set while disarmed")
  `UERA_ASSERT_SAME(a_idle_fields_zero, m_tvalid && !result.distance_valid,
                    result.distance == '0 && result.alarm_mode == ALARM_NONE,
                    "distance fields set without a measurement")
  `UERA_ASSERT_NEXT(a_timeout_disarms, accept && result_next.timed_out,
                    !armed && !echo_high && overflow_count == '0 && m_tvalid,
                    "timeout did not disarm")
  `UERA_ASSERT_NEXT(a_fire_arms, accept && result_next.trigger_fire,
                    armed && m_tvalid && m_tdata[0],
                    "trigger fired without arming")
  `UERA_ASSERT_SAME(a_single_event_kind, m_tvalid,
                    $countones({result.trigger_fire, result.distance_valid,
                                result.timed_out}) <= 1,
                    "one event produced several result kinds")

endmodule
